[hdl/m4inv_pkg.sv]
// Shared types and constants for the 4x4 matrix inverse block.
// Used by m4inv_ctrl, m4inv_dp and the top level; no dependencies.
package m4inv_pkg;

  localparam int unsigned ELEMENT_COUNT = 16;
  localparam int unsigned IDX_W         = $clog2(ELEMENT_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ELEMENT_COUNT - 1);
  localparam int unsigned ELEM_W        = 32;

  // operand, product (also the 2x2 minor), cofactor, determinant, divider and quotient widths
  localparam int unsigned OP_W   = 33;
  localparam int unsigned PROD_W = 66;
  localparam int unsigned CACC_W = 98;
  localparam int unsigned DACC_W = 132;
  localparam int unsigned DIV_W  = 164;
  localparam int unsigned QUO_W  = 33;

  typedef enum logic [2:0] {
    B_MEM, B_T0, B_T1, B_C0, B_C1, B_C2
  } bsel_e;

  typedef enum logic [2:0] {
    ACC_NONE, T_LOAD, T_SUB, C_ADD, C_SUB, D_ADD
  } accop_e;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] rd_addr;
    logic             ld_a;
    logic             mul;
    bsel_e            b_sel;
    accop_e           acc_op;
    logic [1:0]       chunk;
    logic             clr_c;
    logic             clr_d;
    logic             div_load;
    logic             div_step;
    logic             out_load;
    logic [IDX_W-1:0] out_idx;
    logic             singular;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic det_zero;
  } dp_sts_t;

  // store address of element (k, c) of the 3x3 minor that drops row sr and column sc
  function automatic logic [IDX_W-1:0] cof_addr(input logic [1:0] sr, input logic [1:0] sc,
                                                input logic [1:0] k, input logic [1:0] c);
    logic [1:0] row;
    logic [1:0] col;
    row = (k >= sr) ? k + 2'd1 : k;
    col = (c >= sc) ? c + 2'd1 : c;
    return {col, row};
  endfunction

endpackage

[hdl/m4inv_ctrl.sv]
// Sequencer for the 4x4 inverse: cofactor MAC steps, determinant, divide, emit.
// Depends on m4inv_pkg; drives m4inv_dp through dp_cmd_t / dp_sts_t.
module m4inv_ctrl import m4inv_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    load_last_i,
  output logic    in_stall_o,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_CCLR, S_LDA, S_MUL, S_ACC, S_DCHK, S_DIV0, S_DIV, S_EMIT
  } state_e;

  state_e           state_q;
  logic [IDX_W-1:0] idx_q;
  logic [1:0]       j_q;
  logic [1:0]       op_q;
  logic             cofm_q;
  logic             sing_q;
  logic [5:0]       cnt_q;

  logic [1:0] row_o, col_o, j1, j2;
  logic       neg;

  assign row_o = idx_q[1:0];
  assign col_o = idx_q[3:2];
  assign j1    = (j_q == 2'd0) ? 2'd1 : 2'd0;
  assign j2    = (j_q == 2'd2) ? 2'd1 : 2'd2;
  assign neg   = j_q[0] ^ row_o[0] ^ col_o[0];

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o          = '0;
    cmd_o.b_sel    = B_MEM;
    cmd_o.acc_op   = ACC_NONE;
    cmd_o.out_idx  = idx_q;
    cmd_o.singular = sing_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.wr_en = in_valid_i;
        cmd_o.clr_d = in_valid_i & load_last_i;
      end
      S_CCLR: cmd_o.clr_c = 1'b1;
      S_LDA: begin
        cmd_o.ld_a = 1'b1;
        if (!cofm_q) begin
          cmd_o.rd_addr = {2'b00, idx_q[3:2]};
        end else if (op_q == 2'd0) begin
          cmd_o.rd_addr = cof_addr(col_o, row_o, 2'd1, j1);
        end else if (op_q == 2'd1) begin
          cmd_o.rd_addr = cof_addr(col_o, row_o, 2'd1, j2);
        end else begin
          cmd_o.rd_addr = cof_addr(col_o, row_o, 2'd0, j_q);
        end
      end
      S_MUL: begin
        cmd_o.mul     = 1'b1;
        cmd_o.rd_addr = (op_q == 2'd0) ? cof_addr(col_o, row_o, 2'd2, j2)
                                       : cof_addr(col_o, row_o, 2'd2, j1);
        if (cofm_q) begin
          cmd_o.b_sel = (op_q <= 2'd1) ? B_MEM : (op_q == 2'd2) ? B_T0 : B_T1;
        end else begin
          cmd_o.b_sel = (op_q == 2'd0) ? B_C0 : (op_q == 2'd1) ? B_C1 : B_C2;
        end
      end
      S_ACC: begin
        if (cofm_q) begin
          cmd_o.acc_op = (op_q == 2'd0) ? T_LOAD : (op_q == 2'd1) ? T_SUB :
                         neg ? C_SUB : C_ADD;
          cmd_o.chunk  = (op_q == 2'd3) ? 2'd1 : 2'd0;
        end else begin
          cmd_o.acc_op = D_ADD;
          cmd_o.chunk  = op_q;
        end
      end
      S_DCHK: ;
      S_DIV0: cmd_o.div_load = 1'b1;
      S_DIV:  cmd_o.div_step = 1'b1;
      S_EMIT: cmd_o.out_load = sts_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      j_q     <= '0;
      op_q    <= '0;
      cofm_q  <= 1'b0;
      sing_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && load_last_i) begin
            idx_q   <= '0;
            sing_q  <= 1'b0;
            state_q <= S_CCLR;
          end
        end
        S_CCLR: begin
          j_q     <= '0;
          op_q    <= '0;
          cofm_q  <= 1'b1;
          state_q <= S_LDA;
        end
        S_LDA: state_q <= S_MUL;
        S_MUL: state_q <= S_ACC;
        S_ACC: begin
          if (cofm_q) begin
            if (op_q != 2'd3) begin
              op_q    <= op_q + 2'd1;
              state_q <= S_LDA;
            end else if (j_q != 2'd2) begin
              op_q    <= '0;
              j_q     <= j_q + 2'd1;
              state_q <= S_LDA;
            end else if (idx_q[1:0] == 2'd0 && !sing_q && state_q == S_ACC && !cnt_q[5]) begin
              // cofactor done: determinant pass if still in it, else divide
              op_q <= '0;
              if (cnt_q[0]) begin
                state_q <= S_DIV0;
              end else begin
                cofm_q  <= 1'b0;
                state_q <= S_LDA;
              end
            end else begin
              op_q    <= '0;
              state_q <= S_DIV0;
            end
          end else begin
            if (op_q != 2'd2) begin
              op_q    <= op_q + 2'd1;
              state_q <= S_LDA;
            end else if (idx_q == 4'd12) begin
              state_q <= S_DCHK;
            end else begin
              idx_q   <= idx_q + 4'd4;
              state_q <= S_CCLR;
            end
          end
        end
        S_DCHK: begin
          idx_q <= '0;
          cnt_q <= 6'd1;
          if (sts_i.det_zero) begin
            sing_q  <= 1'b1;
            state_q <= S_EMIT;
          end else begin
            state_q <= S_CCLR;
          end
        end
        S_DIV0: begin
          cnt_q   <= 6'd1;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (cnt_q == 6'd33) begin
            cnt_q   <= 6'd1;
            state_q <= S_EMIT;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        S_EMIT: begin
          if (sts_i.out_free) begin
            if (idx_q == LAST_IDX) begin
              sing_q  <= 1'b0;
              cnt_q   <= '0;
              state_q <= S_IDLE;
            end else begin
              idx_q   <= idx_q + 4'd1;
              state_q <= sing_q ? S_EMIT : S_CCLR;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !cmd_o.wr_en)
    else $error("store written while busy");

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV0) |=> (state_q == S_DIV) && (cnt_q == 6'd1))
    else $error("divide sequence start");

endmodule

[hdl/m4inv_dp.sv]
// Datapath for the 4x4 inverse: element store, 33x33 multiplier, exact wide
// accumulators, restoring divider and the output word register. Uses m4inv_pkg.
module m4inv_dp import m4inv_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dp_cmd_t                  cmd_i,
  output dp_sts_t                  sts_o,
  input  logic [IDX_W-1:0]         element_index_i,
  input  logic signed [ELEM_W-1:0] element_value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [IDX_W-1:0]         out_index_o,
  output logic signed [ELEM_W-1:0] out_value_o,
  output logic                     singular_o,
  output logic                     clipped_o,
  output logic                     out_last_o
);

  logic [ELEM_W-1:0]        store_q [ELEMENT_COUNT];
  logic [ELEM_W-1:0]        rd_data;
  logic signed [OP_W-1:0]   opa_q, opb;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] tacc_q;
  logic signed [CACC_W-1:0] cacc_q, csh;
  logic signed [DACC_W-1:0] dacc_q, dsh;
  logic [CACC_W-1:0]        cmag;
  logic [DACC_W-1:0]        dmag;
  logic [DIV_W-1:0]         rem_q, dv_q, rem_ld, dv_ld, dv_sh;
  logic [QUO_W-1:0]         quo_q, limit;
  logic                     big_q, neg_q, clip;
  logic [ELEM_W-1:0]        mag32, val;
  logic                     out_valid_q;

  assign rd_data = store_q[cmd_i.rd_addr];

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      store_q[element_index_i] <= element_value_i;
    end
  end

  always_comb begin
    case (cmd_i.b_sel)
      B_MEM:   opb = {rd_data[ELEM_W-1], rd_data};
      B_T0:    opb = {1'b0, tacc_q[31:0]};
      B_T1:    opb = tacc_q[64:32];
      B_C0:    opb = {1'b0, cacc_q[31:0]};
      B_C1:    opb = {1'b0, cacc_q[63:32]};
      B_C2:    opb = cacc_q[96:64];
      default: opb = '0;
    endcase
  end

  assign csh = (cmd_i.chunk == 2'd1) ? {prod_q, 32'b0} : {{32{prod_q[PROD_W-1]}}, prod_q};

  always_comb begin
    case (cmd_i.chunk)
      2'd1:    dsh = {{34{prod_q[PROD_W-1]}}, prod_q, 32'b0};
      2'd2:    dsh = {{2{prod_q[PROD_W-1]}}, prod_q, 64'b0};
      default: dsh = {{66{prod_q[PROD_W-1]}}, prod_q};
    endcase
  end

  assign cmag   = cacc_q[CACC_W-1] ? CACC_W'(-cacc_q) : cacc_q;
  assign dmag   = dacc_q[DACC_W-1] ? DACC_W'(-dacc_q) : dacc_q;
  assign rem_ld = {34'b0, cmag, 32'b0};
  assign dv_ld  = {dmag[130:0], 33'b0};
  assign dv_sh  = dv_q >> 1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_a) opa_q <= {rd_data[ELEM_W-1], rd_data};
    if (cmd_i.mul)  prod_q <= opa_q * opb;
    if (cmd_i.clr_c) cacc_q <= '0;
    if (cmd_i.clr_d) dacc_q <= '0;
    case (cmd_i.acc_op)
      T_LOAD:  tacc_q <= prod_q;
      T_SUB:   tacc_q <= tacc_q - prod_q;
      C_ADD:   cacc_q <= cacc_q + csh;
      C_SUB:   cacc_q <= cacc_q - csh;
      D_ADD:   dacc_q <= dacc_q + dsh;
      default: ;
    endcase
    if (cmd_i.div_load) begin
      rem_q <= rem_ld;
      dv_q  <= dv_ld;
      quo_q <= '0;
      big_q <= (rem_ld >= dv_ld);
      neg_q <= cacc_q[CACC_W-1] ^ dacc_q[DACC_W-1];
    end else if (cmd_i.div_step) begin
      dv_q <= dv_sh;
      if (rem_q >= dv_sh) begin
        rem_q <= rem_q - dv_sh;
        quo_q <= {quo_q[QUO_W-2:0], 1'b1};
      end else begin
        quo_q <= {quo_q[QUO_W-2:0], 1'b0};
      end
    end
  end

  // saturate to Q16.16
  assign limit = neg_q ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
  assign clip  = big_q || (quo_q > limit);
  assign mag32 = clip ? limit[ELEM_W-1:0] : quo_q[ELEM_W-1:0];
  assign val   = neg_q ? ELEM_W'(32'd0 - mag32) : mag32;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_index_o <= cmd_i.out_idx;
      out_value_o <= cmd_i.singular ? '0 : val;
      singular_o  <= cmd_i.singular;
      clipped_o   <= cmd_i.singular ? 1'b0 : clip;
      out_last_o  <= (cmd_i.out_idx == LAST_IDX);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign sts_o.det_zero  = (dacc_q == '0);

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> sts_o.out_free)
    else $error("output word overwritten");

  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load && cmd_i.singular |=> (out_value_o == '0) && !clipped_o)
    else $error("singular word not zero");

  a_clip_sing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clipped_o |-> !singular_o)
    else $error("clipped on singular word");

endmodule

[hdl/matrix4_inverse_cofactor.sv]
// 4x4 matrix inverse by adjugate, Q16.16 in and out.
// Top level: joins m4inv_ctrl and m4inv_dp; uses m4inv_pkg.
//
// Input channel (in_valid_i / in_stall_o): one word per element, column-major
// index, signed Q16.16 value. load_last_i on a word stores it and starts the
// inversion; in_stall_o stays high until the sixteenth result word is loaded
// into the output register.
// Output channel (out_valid_o / out_stall_i): sixteen words in index order
// 0..15, out_last_o on the last. singular_o marks a zero determinant (value 0).
// clipped_o marks a saturated element.
// Sequencing: one shared 33x33 multiplier does every product, each in the steps
// operand read, multiply, accumulate; a cofactor is 12 products. The determinant
// pass is 4 cofactors plus 12 products. Each result then costs a cofactor plus a
// restoring divide and an emit. A singular matrix emits its sixteen words one per
// cycle after the determinant pass, while the receiver does not stall.
// Reset clears control and the output valid; the element store holds garbage
// until written. A stalled receiver holds the output word and pauses the block.
module matrix4_inverse_cofactor import m4inv_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [IDX_W-1:0]         element_index_i,
  input  logic signed [ELEM_W-1:0] element_value_i,
  input  logic                     load_last_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [IDX_W-1:0]         out_index_o,
  output logic signed [ELEM_W-1:0] out_value_o,
  output logic                     singular_o,
  output logic                     clipped_o,
  output logic                     out_last_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  m4inv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .load_last_i (load_last_i),
    .in_stall_o  (in_stall_o),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  m4inv_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .element_index_i (element_index_i),
    .element_value_i (element_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_index_o     (out_index_o),
    .out_value_o     (out_value_o),
    .singular_o      (singular_o),
    .clipped_o       (clipped_o),
    .out_last_o      (out_last_o)
  );

endmodule

[tb/sv/matrix4_inverse_cofactor_test.sv]
// Testbench for matrix4_inverse_cofactor: loads 4x4 Q16.16 matrices and checks every
// inverse word against an exact wide-integer adjugate predictor. Depends on m4inv_pkg.
`timescale 1ns / 1ps

module matrix4_inverse_cofactor_test;
  import m4inv_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 216;
  localparam int unsigned CYCLE_LIMIT  = 2000000;
  localparam logic [31:0] ONE_Q16      = 32'h0001_0000;

  typedef logic signed [191:0] exact_t;

  typedef struct packed {
    logic [3:0]  index;
    logic [31:0] value;
    logic        singular;
    logic        clipped;
    logic        last;
  } inv_word_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [IDX_W-1:0]         element_index_i;
  logic signed [ELEM_W-1:0] element_value_i;
  logic                     load_last_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [IDX_W-1:0]         out_index_o;
  logic signed [ELEM_W-1:0] out_value_o;
  logic                     singular_o;
  logic                     clipped_o;
  logic                     out_last_o;

  logic signed [31:0] matrix_copy [16];
  inv_word_t          inverse_q[$];
  int unsigned        errors;
  int unsigned        cycles;
  int unsigned        items_sent;
  int unsigned        words_checked;
  int unsigned        matrices;
  int unsigned        burst_left;
  int unsigned        gap_max;
  int unsigned        stall_mode;
  int unsigned        hold_left;
  logic               hold_req;

  matrix4_inverse_cofactor dut (.*);

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: stall pattern per mode, plus an optional long hold-off
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
    end else if (hold_req && hold_left == 0) begin
      hold_left   <= 2500;
      out_stall_i <= 1'b1;
    end else if (hold_left > 1) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      if (hold_left == 1) hold_left <= 0;
      case (stall_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 3) == 0);
        2:       out_stall_i <= cycles[2];
        default: out_stall_i <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  function automatic exact_t elem_at(int row, int col);
    return exact_t'(matrix_copy[col*4 + row]);
  endfunction

  function automatic exact_t minor_det(int skip_row, int skip_col);
    int     rs[3];
    int     cs[3];
    int     n;
    exact_t e[3][3];
    n = 0;
    for (int k = 0; k < 4; k++) if (k != skip_row) begin rs[n] = k; n++; end
    n = 0;
    for (int k = 0; k < 4; k++) if (k != skip_col) begin cs[n] = k; n++; end
    for (int k = 0; k < 3; k++)
      for (int j = 0; j < 3; j++) e[k][j] = elem_at(rs[k], cs[j]);
    return e[0][0] * (e[1][1] * e[2][2] - e[1][2] * e[2][1])
         - e[0][1] * (e[1][0] * e[2][2] - e[1][2] * e[2][0])
         + e[0][2] * (e[1][0] * e[2][1] - e[1][1] * e[2][0]);
  endfunction

  task automatic predict_inverse();
    exact_t    det;
    exact_t    cof;
    exact_t    quo;
    inv_word_t w;
    det = '0;
    for (int r = 0; r < 4; r++) begin
      if (r % 2) det = det - elem_at(r, 0) * minor_det(r, 0);
      else       det = det + elem_at(r, 0) * minor_det(r, 0);
    end
    for (int i = 0; i < 16; i++) begin
      w.index    = 4'(i);
      w.singular = (det == 0);
      w.clipped  = 1'b0;
      w.value    = '0;
      w.last     = (i == 15);
      if (det != 0) begin
        cof = minor_det(i / 4, i % 4);
        if (((i % 4) + (i / 4)) % 2) cof = -cof;
        quo = (cof <<< 32) / det;
        if (quo > exact_t'(32'sh7FFF_FFFF)) begin
          w.value = 32'h7FFF_FFFF; w.clipped = 1'b1;
        end else if (quo < -(exact_t'(1) <<< 31)) begin
          w.value = 32'h8000_0000; w.clipped = 1'b1;
        end else begin
          w.value = quo[31:0];
        end
      end
      inverse_q.push_back(w);
    end
    matrices++;
  endtask

  always @(posedge clk_i) begin
    inv_word_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      words_checked++;
      if (inverse_q.size() == 0) begin
        errors++;
        $error("unexpected word index=%0d value=%h", out_index_o, out_value_o);
      end else begin
        w = inverse_q.pop_front();
        if (out_index_o !== w.index) begin
          errors++; $error("out_index exp %0d got %0d", w.index, out_index_o);
        end
        if (out_value_o !== w.value) begin
          errors++; $error("out_value exp %h got %h", w.value, out_value_o);
        end
        if (singular_o !== w.singular) begin
          errors++; $error("singular exp %b got %b", w.singular, singular_o);
        end
        if (clipped_o !== w.clipped) begin
          errors++; $error("clipped exp %b got %b", w.clipped, clipped_o);
        end
        if (out_last_o !== w.last) begin
          errors++; $error("out_last exp %b got %b", w.last, out_last_o);
        end
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input logic [3:0] idx, input logic [31:0] val, input logic last);
    if (burst_left == 0) begin
      if (gap_max > 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i      <= 1'b1;
    element_index_i <= idx;
    element_value_i <= val;
    load_last_i     <= last;
    do @(posedge clk_i); while (in_stall_o);
    matrix_copy[idx] = val;
    if (last) predict_inverse();
    burst_left--;
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_matrix(input logic [31:0] m [16]);
    int order[16];
    int j;
    int t;
    for (int i = 0; i < 16; i++) order[i] = i;
    for (int i = 15; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i]; order[i] = order[j]; order[j] = t;
    end
    for (int i = 0; i < 16; i++) send_word(4'(order[i]), m[order[i]], i == 15);
  endtask

  function automatic logic [31:0] rand_elem(int unsigned kind, int i);
    logic [31:0] v;
    case (kind)
      0: v = ((i % 5 == 0) ? ONE_Q16 * $urandom_range(1, 4) : 32'h0)
             + 32'($signed($urandom_range(0, 32'h8000)) - 32'sh4000);
      1: v = $urandom;
      2: v = 32'($signed($urandom_range(0, 32'h7FFFF)) - 32'sh3FFFF);
      default: v = ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
    return v;
  endfunction

  task automatic test_identity();
    logic [31:0] m [16];
    for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? ONE_Q16 : 32'h0;
    for (int i = 0; i < 16; i++) send_word(4'(i), m[i], i == 15);
  endtask

  task automatic test_extreme_diagonal();
    send_word(4'd0,  32'h0000_0001, 1'b0);
    send_word(4'd5,  32'hFFFF_FFFF, 1'b0);
    send_word(4'd10, 32'h7FFF_FFFF, 1'b0);
    send_word(4'd15, 32'h8000_0000, 1'b1);
  endtask

  task automatic test_singular();
    // column 1 becomes a copy of column 0
    send_word(4'd4, 32'h0000_0001, 1'b0);
    send_word(4'd5, 32'h0000_0000, 1'b1);
  endtask

  task automatic test_backpressure();
    logic [31:0] m [16];
    for (int i = 0; i < 16; i++) m[i] = rand_elem(0, i);
    hold_req = 1'b1;
    send_matrix(m);
    hold_req = 1'b0;
    for (int i = 0; i < 16; i++) m[i] = rand_elem(2, i);
    send_matrix(m);
  endtask

  task automatic test_random();
    logic [31:0] m [16];
    int unsigned kind;
    int unsigned n;
    int unsigned goal;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      stall_mode = $urandom_range(0, 3);
      gap_max    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      kind       = $urandom_range(0, 9);
      if (kind < 2) begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
          send_word(4'($urandom), rand_elem($urandom_range(0, 3), i), i == n - 1);
      end else begin
        kind = (kind < 6) ? 0 : (kind < 8) ? 2 : (kind < 9) ? 1 : 3;
        for (int i = 0; i < 16; i++) m[i] = rand_elem(kind, i);
        if ($urandom_range(0, 5) == 0)
          for (int r = 0; r < 4; r++) m[12 + r] = m[4 + r];
        send_matrix(m);
      end
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    element_index_i = '0;
    element_value_i = '0;
    load_last_i     = 1'b0;
    hold_req        = 1'b0;
    stall_mode      = 0;
    gap_max         = 0;
    burst_left      = 0;
    errors          = 0;
    cycles          = 0;
    items_sent      = 0;
    words_checked   = 0;
    matrices        = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_identity();
    stall_mode = 1;
    gap_max    = 4;
    test_extreme_diagonal();
    test_singular();
    stall_mode = 2;
    test_backpressure();
    test_random();

    in_valid_i <= 1'b0;
    wait (inverse_q.size() == 0);
    repeat (200) @(posedge clk_i);

    $display("%0d words loaded, %0d matrices inverted, %0d inverse words checked",
             items_sent, matrices, words_checked);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[matrix4_inverse_cofactor.f]
hdl/m4inv_pkg.sv
hdl/m4inv_ctrl.sv
hdl/m4inv_dp.sv
hdl/matrix4_inverse_cofactor.sv
tb/sv/matrix4_inverse_cofactor_test.sv
